// ===== rtl/core/fpda_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and defaults for the fixed-point to decimal text converter.
package fpda_pkg;

    // Default geometry of the input number and the fraction digit limit
    localparam int INT_BITS_DEF      = 32;
    localparam int FRAC_BITS_DEF     = 16;
    localparam int MAX_PRECISION_DEF = 8;

    // Integer digit store: enough for the widest integer part (2^31 has 10 digits)
    localparam int DIGIT_DEPTH = 10;
    localparam int DIGIT_IDX_W = $clog2(DIGIT_DEPTH);
    localparam int DIGIT_CNT_W = $clog2(DIGIT_DEPTH + 1);

    // Divide-by-ten unit: q = (x * RECIP_10) >> RECIP_SHIFT, exact for any 32-bit x
    localparam int          ALU_W       = 32;
    localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    // Characters
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;

    // Configuration port
    localparam int                  APB_ADDR_W         = 3;
    localparam int                  APB_DATA_W         = 32;
    localparam logic [APB_ADDR_W-1:0] REG_PRECISION_ADDR = 3'd0;
    localparam int                  PREC_W             = 4;
    localparam logic [PREC_W-1:0]   PREC_RESET         = 4'd2;

    // Sequencer states
    typedef enum logic [6:0] {
        ST_IDLE      = 7'b000_0001,
        ST_DIV_ISSUE = 7'b000_0010,
        ST_DIV_TAKE  = 7'b000_0100,
        ST_SIGN      = 7'b000_1000,
        ST_INT       = 7'b001_0000,
        ST_DOT       = 7'b010_0000,
        ST_FRAC      = 7'b100_0000
    } seq_state_t;

    // Result of one divide-by-ten pass
    typedef struct packed {
        logic [ALU_W-1:0] quot;
        logic [3:0]       rem;
    } div_res_t;

endpackage

// ===== rtl/core/fixed_point_to_decimal_ascii.sv =====
`timescale 1ns / 1ps
// Top level: signed fixed-point number in, decimal ASCII text out, one character per word.
//
// Each input word is one signed two's complement number with INT_BITS integer bits and
// FRAC_BITS fraction bits (Q31.16 by default). The block answers with its decimal text,
// one character per output word: '-' for a negative number, the integer digits most
// significant first ('0' for a zero integer part), then, if precision is nonzero, '.'
// and precision fraction digits (truncated, exact). m_tlast marks the final character.
// The precision register (byte address 0, 4 bits, reset 2) is applied capped at MAX_PRECISION;
// write it only while no conversion is in progress. The input word is taken, then the
// integer part goes through one shared divide-by-ten unit, one digit per pass (reciprocal
// multiply, then remainder correction), and after that one character leaves per cycle
// while m_tready is high. s_tready is high only between numbers; the next number can be
// taken while the final character still waits in the output register.
module fixed_point_to_decimal_ascii #(
    parameter int INT_BITS      = fpda_pkg::INT_BITS_DEF,
    parameter int FRAC_BITS     = fpda_pkg::FRAC_BITS_DEF,
    parameter int MAX_PRECISION = fpda_pkg::MAX_PRECISION_DEF,
    parameter int TDATA_W       = ((INT_BITS + FRAC_BITS + 7) / 8) * 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [TDATA_W-1:0]                 s_tdata,   // [INT_BITS+FRAC_BITS-1:0] value
    // output stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,   // [7:0] char_code
    output logic                               m_tlast,   // last_char
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fpda_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [fpda_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [fpda_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import fpda_pkg::*;

    localparam int TOTAL = INT_BITS + FRAC_BITS;

    logic [PREC_W-1:0]    precision_reg;
    logic                 div_load;
    logic [ALU_W-1:0]     div_operand;
    div_res_t             div_res;
    logic [FRAC_BITS-1:0] frac_val;
    logic [3:0]           frac_digit;
    logic [FRAC_BITS-1:0] frac_rest;

    // config register: always ready, written on the access phase
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            precision_reg <= PREC_RESET;
        end else if (psel && penable && pwrite && pready && paddr == REG_PRECISION_ADDR) begin
            precision_reg <= pwdata[PREC_W-1:0];
        end
    end

    assign prdata = (paddr == REG_PRECISION_ADDR) ? APB_DATA_W'(precision_reg) : '0;

    fpda_seq #(
        .INT_BITS      (INT_BITS),
        .FRAC_BITS     (FRAC_BITS),
        .MAX_PRECISION (MAX_PRECISION)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .value       (s_tdata[TOTAL-1:0]),
        .precision   (precision_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_char    (m_tdata),
        .out_last    (m_tlast),
        .div_load    (div_load),
        .div_operand (div_operand),
        .div_res     (div_res),
        .frac_out    (frac_val),
        .frac_digit  (frac_digit),
        .frac_rest   (frac_rest)
    );

    fpda_alu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_alu (
        .aclk        (aclk),
        .div_load    (div_load),
        .div_operand (div_operand),
        .div_res     (div_res),
        .frac_in     (frac_val),
        .frac_digit  (frac_digit),
        .frac_rest   (frac_rest)
    );

endmodule

// ===== rtl/core/fpda_alu.sv =====
`timescale 1ns / 1ps
// Shared arithmetic unit: registered divide by ten and combinational multiply of the fraction by ten.
module fpda_alu #(
    parameter int FRAC_BITS = fpda_pkg::FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          div_load,
    input  logic [fpda_pkg::ALU_W-1:0]    div_operand,
    output fpda_pkg::div_res_t            div_res,
    input  logic [FRAC_BITS-1:0]          frac_in,
    output logic [3:0]                    frac_digit,
    output logic [FRAC_BITS-1:0]          frac_rest
);
    import fpda_pkg::*;

    logic [ALU_W-1:0]   x_reg;
    logic [2*ALU_W-1:0] prod_reg;
    logic [ALU_W-1:0]   quot;
    logic [ALU_W-1:0]   quot_x10;
    logic [ALU_W-1:0]   rem_full;
    logic [FRAC_BITS+3:0] frac_ext;
    logic [FRAC_BITS+3:0] frac_x10;

    // reciprocal product, registered before the correction step
    always_ff @(posedge aclk) begin
        if (div_load) begin
            x_reg    <= div_operand;
            prod_reg <= {{ALU_W{1'b0}}, div_operand} * {{ALU_W{1'b0}}, RECIP_10};
        end
    end

    always_comb begin
        quot     = ALU_W'(prod_reg[2*ALU_W-1:RECIP_SHIFT]);
        quot_x10 = (quot << 3) + (quot << 1);
        rem_full = x_reg - quot_x10;
        div_res.quot = quot;
        div_res.rem  = rem_full[3:0];
    end

    // fraction times ten: shift and add
    always_comb begin
        frac_ext   = {4'b0000, frac_in};
        frac_x10   = (frac_ext << 3) + (frac_ext << 1);
        frac_digit = frac_x10[FRAC_BITS+3:FRAC_BITS];
        frac_rest  = frac_x10[FRAC_BITS-1:0];
    end

endmodule

// ===== rtl/core/fpda_seq.sv =====
`timescale 1ns / 1ps
// Sequencer: splits the number, drives the shared unit, holds digits, emits characters.
module fpda_seq #(
    parameter int INT_BITS      = fpda_pkg::INT_BITS_DEF,
    parameter int FRAC_BITS     = fpda_pkg::FRAC_BITS_DEF,
    parameter int MAX_PRECISION = fpda_pkg::MAX_PRECISION_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [INT_BITS+FRAC_BITS-1:0]     value,
    input  logic [fpda_pkg::PREC_W-1:0]       precision,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [7:0]                        out_char,
    output logic                              out_last,
    output logic                              div_load,
    output logic [fpda_pkg::ALU_W-1:0]        div_operand,
    input  fpda_pkg::div_res_t                div_res,
    output logic [FRAC_BITS-1:0]              frac_out,
    input  logic [3:0]                        frac_digit,
    input  logic [FRAC_BITS-1:0]              frac_rest
);
    import fpda_pkg::*;

    localparam int TOTAL = INT_BITS + FRAC_BITS;

    seq_state_t state_reg, state_next;

    logic [ALU_W-1:0]       int_reg;
    logic [FRAC_BITS-1:0]   frac_reg;
    logic [3:0]             digit_mem [DIGIT_DEPTH];
    logic [3:0]             digit_rd_reg;
    logic [DIGIT_CNT_W-1:0] count_reg;
    logic [DIGIT_CNT_W-1:0] count_dec;
    logic [DIGIT_CNT_W-1:0] count_dec2;
    logic [PREC_W-1:0]      frac_left_reg;
    logic [PREC_W-1:0]      prec_sat;
    logic                   neg_reg;
    logic                   out_valid_reg;
    logic [7:0]             out_char_reg;
    logic                   out_last_reg;

    logic                   slot_free;
    logic                   load;
    logic [7:0]             load_char;
    logic                   load_last;
    logic [TOTAL-1:0]       mag;
    logic                   div_done;

    assign slot_free  = !out_valid_reg || out_ready;
    assign count_dec  = count_reg - DIGIT_CNT_W'(1);
    assign count_dec2 = count_reg - DIGIT_CNT_W'(2);
    assign prec_sat   = (precision > PREC_W'(MAX_PRECISION)) ? PREC_W'(MAX_PRECISION)
                                                             : precision;
    assign mag        = value[TOTAL-1] ? (~value + TOTAL'(1)) : value;
    assign div_done   = (div_res.quot == '0) ||
                        (count_reg == DIGIT_CNT_W'(DIGIT_DEPTH - 1));

    assign in_ready    = (state_reg == ST_IDLE);
    assign div_load    = (state_reg == ST_DIV_ISSUE);
    assign div_operand = int_reg;
    assign frac_out    = frac_reg;
    assign out_valid   = out_valid_reg;
    assign out_char    = out_char_reg;
    assign out_last    = out_last_reg;

    always_comb begin
        state_next = state_reg;
        load       = 1'b0;
        load_char  = CHAR_ZERO;
        load_last  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) state_next = ST_DIV_ISSUE;
            end
            ST_DIV_ISSUE: begin
                state_next = ST_DIV_TAKE;
            end
            ST_DIV_TAKE: begin
                if (div_done) state_next = neg_reg ? ST_SIGN : ST_INT;
                else          state_next = ST_DIV_ISSUE;
            end
            ST_SIGN: begin
                if (slot_free) begin
                    load       = 1'b1;
                    load_char  = CHAR_MINUS;
                    state_next = ST_INT;
                end
            end
            ST_INT: begin
                if (slot_free) begin
                    load      = 1'b1;
                    load_char = CHAR_ZERO + {4'b0000, digit_rd_reg};
                    load_last = (count_reg == DIGIT_CNT_W'(1)) && (frac_left_reg == '0);
                    if (count_reg == DIGIT_CNT_W'(1))
                        state_next = (frac_left_reg == '0) ? ST_IDLE : ST_DOT;
                end
            end
            ST_DOT: begin
                if (slot_free) begin
                    load       = 1'b1;
                    load_char  = CHAR_DOT;
                    state_next = ST_FRAC;
                end
            end
            ST_FRAC: begin
                if (slot_free) begin
                    load      = 1'b1;
                    load_char = CHAR_ZERO + {4'b0000, frac_digit};
                    load_last = (frac_left_reg == PREC_W'(1));
                    if (frac_left_reg == PREC_W'(1)) state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load)           out_valid_reg <= 1'b1;
            else if (out_ready) out_valid_reg <= 1'b0;
        end
    end

    // working values and output word
    always_ff @(posedge aclk) begin
        if (load) begin
            out_char_reg <= load_char;
            out_last_reg <= load_last;
        end
        if (state_reg == ST_IDLE && in_valid) begin
            neg_reg       <= value[TOTAL-1];
            int_reg       <= ALU_W'(mag[TOTAL-1:FRAC_BITS]);
            frac_reg      <= mag[FRAC_BITS-1:0];
            count_reg     <= '0;
            frac_left_reg <= prec_sat;
        end
        // newest digit is the most significant one, so it is the first to go out
        if (state_reg == ST_DIV_TAKE) begin
            digit_mem[count_reg[DIGIT_IDX_W-1:0]] <= div_res.rem;
            digit_rd_reg <= div_res.rem;
            int_reg   <= div_res.quot;
            count_reg <= count_reg + DIGIT_CNT_W'(1);
        end
        // fetch the next lower digit while the current one leaves
        if (state_reg == ST_INT && slot_free) begin
            count_reg <= count_dec;
            if (count_reg != DIGIT_CNT_W'(1))
                digit_rd_reg <= digit_mem[count_dec2[DIGIT_IDX_W-1:0]];
        end
        if (state_reg == ST_FRAC && slot_free) begin
            frac_reg      <= frac_rest;
            frac_left_reg <= frac_left_reg - PREC_W'(1);
        end
    end

endmodule

// ===== rtl/core/fpda_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the converter, bound to the top level.
module fpda_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);
    import fpda_pkg::*;

    logic out_digit;
    assign out_digit = (m_tdata >= CHAR_ZERO) && (m_tdata <= CHAR_ZERO + 8'd9);

    // the input closes once a number has been taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a number was taken");

    // text runs without gaps until its final character
    a_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside a number's text");

    // only digits, minus and dot appear
    a_char_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> out_digit || m_tdata == CHAR_MINUS || m_tdata == CHAR_DOT)
        else $error("unexpected character");

    // text always ends on a digit
    a_last_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> out_digit)
        else $error("final character is not a digit");

endmodule

bind fixed_point_to_decimal_ascii fpda_checker u_fpda_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== tb/sv/tb_fixed_point_to_decimal_ascii.sv =====
`timescale 1ns / 1ps
// Testbench for the fixed-point to decimal ASCII converter: directed and random numbers.

// Expected text of each accepted number, checked one character word at a time
class text_scoreboard;
    typedef struct {
        logic [7:0] code;
        logic       is_last;
    } text_char_t;

    text_char_t expected_chars[$];
    int         errors;

    function new();
        errors = 0;
    endfunction

    // Convert one accepted number into the character words it must produce
    function void note_number(logic [47:0] value, logic [3:0] prec_reg);
        logic        neg;
        logic [47:0] mag;
        logic [31:0] int_part;
        logic [15:0] frac_part;
        logic [19:0] prod;
        logic [7:0]  int_chars[$];
        text_char_t  c;
        int          n_int;
        int          n_frac;
        neg       = value[47];
        mag       = neg ? (~value + 48'd1) : value;
        int_part  = mag[47:16];
        frac_part = mag[15:0];
        n_int     = 0;
        // least significant digit first, at most ten digits
        do begin
            int_chars.push_front(fpda_pkg::CHAR_ZERO + 8'(int_part % 32'd10));
            int_part = int_part / 32'd10;
            n_int++;
        end while (int_part != 0 && n_int < fpda_pkg::DIGIT_DEPTH);
        c.is_last = 1'b0;
        if (neg) begin
            c.code = fpda_pkg::CHAR_MINUS;
            expected_chars.push_back(c);
        end
        foreach (int_chars[i]) begin
            c.code = int_chars[i];
            expected_chars.push_back(c);
        end
        n_frac = (prec_reg > fpda_pkg::MAX_PRECISION_DEF) ? fpda_pkg::MAX_PRECISION_DEF
                                                          : int'(prec_reg);
        if (n_frac > 0) begin
            c.code = fpda_pkg::CHAR_DOT;
            expected_chars.push_back(c);
            repeat (n_frac) begin
                prod      = 20'(frac_part) * 20'd10;
                c.code    = fpda_pkg::CHAR_ZERO + 8'(prod[19:16]);
                frac_part = prod[15:0];
                expected_chars.push_back(c);
            end
        end
        expected_chars[expected_chars.size() - 1].is_last = 1'b1;
    endfunction

    function void check_char(logic [7:0] code, logic is_last);
        text_char_t want;
        if (expected_chars.size() == 0) begin
            $error("unexpected character word: char_code %h last_char %b", code, is_last);
            errors++;
            return;
        end
        want = expected_chars.pop_front();
        if (code !== want.code) begin
            $error("char_code mismatch: expected %h, actual %h", want.code, code);
            errors++;
        end
        if (is_last !== want.is_last) begin
            $error("last_char mismatch: expected %b, actual %b", want.is_last, is_last);
            errors++;
        end
    endfunction

    function int pending();
        return expected_chars.size();
    endfunction
endclass

module tb_fixed_point_to_decimal_ascii;
    import fpda_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int SETTLE_CYCLES = 50;    // idle time after the last expected character
    localparam int N_DIRECTED = 22;
    localparam int N_RAND_PHASES = 7;
    localparam int WORDS_PER_PHASE = 27;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [47:0]           s_tdata = '0;   // [47:0] value
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;        // [7:0] char_code
    logic                  m_tlast;        // last_char
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    text_scoreboard sb = new();

    logic [3:0] prec_shadow = PREC_RESET;  // what the precision register holds now
    int         tx_idle_pct = 0;           // chance of a sender gap before a word
    int         rx_stall_pct = 0;          // chance of a receiver stall burst
    int         rx_stall_left = 0;
    int         cycle_count = 0;

    fixed_point_to_decimal_ascii i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // run watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver back-pressure: random stall bursts
    always @(posedge aclk) begin
        if (rx_stall_left > 0) begin
            m_tready      <= 1'b0;
            rx_stall_left <= rx_stall_left - 1;
        end else if (aresetn && $urandom_range(0, 99) < rx_stall_pct) begin
            m_tready      <= 1'b0;
            rx_stall_left <= $urandom_range(1, 17) - 1;
        end else begin
            m_tready <= aresetn;
        end
    end

    // output monitor: every accepted character word goes to the scoreboard
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_char(m_tdata, m_tlast);
    end

    // one number word; s_tvalid stays high afterwards unless the next call gaps or drains
    task automatic send_number(logic [47:0] value);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 48'({$urandom(), $urandom()});   // junk while idle
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        sb.note_number(value, prec_shadow);
    endtask

    // sender pauses until every expected character has come out
    task automatic drain_output();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_access(logic wr, logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= REG_PRECISION_ADDR;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // idle-only register update, read back to confirm
    task automatic set_precision(logic [3:0] prec);
        logic [APB_DATA_W-1:0] rd;
        drain_output();
        // upper bits are don't-care for a 4-bit register
        apb_access(1'b1, {28'($urandom_range(0, 32'h0FFF_FFFF)), prec}, rd);
        prec_shadow = prec;
        apb_access(1'b0, '0, rd);
        if (rd !== APB_DATA_W'(prec)) begin
            $error("precision readback mismatch: expected %h, actual %h",
                   APB_DATA_W'(prec), rd);
            sb.errors++;
        end
    endtask

    // random number: mostly short integer parts, some raw patterns and extremes
    function automatic logic [47:0] rand_number();
        logic [31:0] pow10;
        logic [31:0] int_part;
        logic [47:0] mag;
        int          kind;
        kind = $urandom_range(0, 9);
        if (kind <= 2)
            return 48'({$urandom(), $urandom()});
        pow10 = 32'd1;
        repeat ($urandom_range(1, 9)) pow10 = pow10 * 32'd10;
        case (kind)
            8: begin
                int_part = '0;
            end
            9: begin
                // all nines or a power of ten, or the widest positive
                case ($urandom_range(0, 2))
                    0: int_part = pow10 - 32'd1;
                    1: int_part = pow10;
                    default: int_part = 32'h7FFF_FFFF;
                endcase
            end
            default: begin
                int_part = $urandom() % pow10;
            end
        endcase
        mag = {int_part, 16'($urandom())};
        if ($urandom_range(0, 1))
            mag = ~mag + 48'd1;
        return mag;
    endfunction

    logic [47:0] dir_vals [N_DIRECTED] = '{
        48'h0000_0000_0000,     // zero
        48'h0000_0000_0001,     // smallest positive
        48'hFFFF_FFFF_FFFF,     // -2^-16: minus sign, zero integer part
        48'h7FFF_FFFF_FFFF,     // largest value
        48'h8000_0000_0000,     // most negative: magnitude 2^31 exactly
        48'hFFFF_FFFF_8000,     // -0.5
        48'h0000_0009_FFFF,     // 9 + max fraction
        48'h0000_000A_0000,     // 10
        48'h3B9A_C9FF_8000,     // 999999999.5
        48'h3B9A_CA00_0000,     // 1000000000
        48'h7FFF_FFFF_FFFF,
        48'h8000_0000_0000,
        48'hFFFF_FFFF_FFFF,
        48'h0000_002A_4000,
        48'h0000_0000_FFFF,     // max fraction, eight digits
        48'h0000_0000_0001,
        48'hFFFF_FFFF_0001,
        48'h8000_0000_0000,
        48'h0000_0003_243F,     // above the digit limit: saturates
        48'hFFFF_FFFE_DBC1,
        48'h0001_E240_1234,
        48'hFFFE_1DBF_E667
    };
    // precision per directed word; the first group runs on the reset value
    logic [3:0] dir_prec [N_DIRECTED] = '{
        4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2,
        4'd0, 4'd0, 4'd0, 4'd0,
        4'd8, 4'd8, 4'd8, 4'd8,
        4'd15, 4'd15,
        4'd9, 4'd1
    };
    logic [3:0] phase_prec [N_RAND_PHASES];

    initial begin
        phase_prec = '{4'd0, 4'd8, 4'd15, 4'd1, 4'($urandom_range(0, 15)), 4'd3,
                       4'($urandom_range(0, 15))};
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part, moderate idling
        tx_idle_pct  = 20;
        rx_stall_pct = 10;
        for (int i = 0; i < N_DIRECTED; i++) begin
            if (dir_prec[i] != prec_shadow)
                set_precision(dir_prec[i]);
            send_number(dir_vals[i]);
        end

        // random part: idling varies per phase, none in the last phase
        for (int p = 0; p < N_RAND_PHASES; p++) begin
            set_precision(phase_prec[p]);
            if (p == N_RAND_PHASES - 1) begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end else begin
                tx_idle_pct  = (p % 3 == 1) ? 0 : $urandom_range(5, 40);
                rx_stall_pct = (p % 3 == 2) ? 0 : $urandom_range(5, 30);
            end
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                send_number(rand_number());
                // one full pause mid-phase, in phase 2 only
                if (n == WORDS_PER_PHASE / 2 && p == 2)
                    drain_output();
            end
        end

        drain_output();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
